>>> hw/rtl/ptwe_pkg.sv
// ---------------------------------------------------------------------------
// ptwe_pkg
// Shared widths, status codes, register indexes and the control/status
// structs of the page table translator.
// ---------------------------------------------------------------------------
`default_nettype none

package ptwe_pkg;

    localparam int PROC_W  = 2;
    localparam int ADDR_W  = 31;
    localparam int PHYS_W  = 22;
    localparam int STAT_W  = 3;
    localparam int CNT_W   = 32;
    localparam int PAGES_W = 11;
    localparam int CFG_W   = 11;
    localparam int CIDX_W  = 1;

    // 4096-byte pages, 1024 virtual pages per process, 1024 frames
    localparam int OFF_W   = 12;
    localparam int VPN_W   = 10;
    localparam int FRAME_W = 10;
    localparam int NUM_PROCS = 4;
    localparam int SLOT_W  = PROC_W + VPN_W;

    // valid bits kept as 64-bit rows, 16 rows per process
    localparam int BIT_W   = 6;
    localparam int WORD_W  = 1 << BIT_W;
    localparam int ROW_W   = VPN_W - BIT_W;
    localparam int ROWS_PER_PROC = 1 << ROW_W;
    localparam int VROW_W  = PROC_W + ROW_W;
    localparam int NUM_ROWS = 1 << VROW_W;
    localparam int NUM_SLOTS = 1 << SLOT_W;

    localparam logic [PAGES_W-1:0] PHYS_PAGES    = 11'd1024;
    localparam logic [CFG_W-1:0]   TOTAL_RST     = 11'd1024;
    localparam logic [CFG_W-1:0]   RESERVED_RST  = 11'd256;

    localparam logic [STAT_W-1:0] ST_HIT     = 3'd0;
    localparam logic [STAT_W-1:0] ST_FREE    = 3'd1;
    localparam logic [STAT_W-1:0] ST_EVICT   = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOFRAME = 3'd3;
    localparam logic [STAT_W-1:0] ST_RANGE   = 3'd4;

    localparam logic [CIDX_W-1:0] CFG_TOTAL    = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_RESERVED = 1'b1;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic resolve;
        logic ev_clear;
        logic ev_finish;
        logic push;
    } ptwe_cmd_t;

    typedef struct packed {
        logic evict;
        logic out_free;
    } ptwe_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/ptwe_req_if.sv
// ---------------------------------------------------------------------------
// ptwe_req_if
// Request channel: one translation item per handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface ptwe_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  proc_id;
    logic [30:0] address;

    modport source (output valid, output proc_id, output address, input ready);
    modport sink   (input valid, input proc_id, input address, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ptwe_rsp_if.sv
// ---------------------------------------------------------------------------
// ptwe_rsp_if
// Result channel: translated address, status and counters per item.
// ---------------------------------------------------------------------------
`default_nettype none

interface ptwe_rsp_if;
    logic        valid;
    logic        ready;
    logic [21:0] phys_address;
    logic [2:0]  status;
    logic [31:0] access_count;
    logic [31:0] hit_count;
    logic [31:0] from_free_count;
    logic [31:0] fault_count;
    logic [10:0] used_pages;
    logic [10:0] free_pages;

    modport source (output valid, output phys_address, output status,
                    output access_count, output hit_count, output from_free_count,
                    output fault_count, output used_pages, output free_pages,
                    input ready);
    modport sink   (input valid, input phys_address, input status,
                    input access_count, input hit_count, input from_free_count,
                    input fault_count, input used_pages, input free_pages,
                    output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ptwe_ram.sv
// ---------------------------------------------------------------------------
// ptwe_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module ptwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ptwe_ctrl.sv
// ---------------------------------------------------------------------------
// ptwe_ctrl
// Sequencer: capture, table read, resolve, optional eviction, push.
// ---------------------------------------------------------------------------
`default_nettype none

module ptwe_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire ptwe_pkg::ptwe_stat_t  stat,
    output ptwe_pkg::ptwe_cmd_t        cmd
);
    import ptwe_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_LOOK = 3'd2;
    localparam logic [2:0] S_EVW  = 3'd3;
    localparam logic [2:0] S_EVF  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign req_ready     = (state_reg == S_IDLE);
    assign cmd.capture   = req_ready && req_valid;
    assign cmd.lookup    = (state_reg == S_READ);
    assign cmd.resolve   = (state_reg == S_LOOK);
    assign cmd.ev_clear  = (state_reg == S_EVW);
    assign cmd.ev_finish = (state_reg == S_EVF);
    assign cmd.push      = (state_reg == S_DONE) && stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (req_valid) state_next = S_READ;
            S_READ: state_next = S_LOOK;
            S_LOOK: state_next = stat.evict ? S_EVW : S_DONE;
            S_EVW:  state_next = S_EVF;
            S_EVF:  state_next = S_DONE;
            S_DONE: if (stat.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ptwe_dp.sv
// ---------------------------------------------------------------------------
// ptwe_dp
// Datapath: page tables, valid rows, free pool, counters, result register.
// ---------------------------------------------------------------------------
`default_nettype none

module ptwe_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire ptwe_pkg::ptwe_cmd_t             cmd,
    output ptwe_pkg::ptwe_stat_t                 stat,
    input  wire logic [ptwe_pkg::PROC_W-1:0]     proc_id,
    input  wire logic [ptwe_pkg::ADDR_W-1:0]     address,
    input  wire logic                            cfg_we,
    input  wire logic [ptwe_pkg::CIDX_W-1:0]     cfg_index,
    input  wire logic [ptwe_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                            rsp_ready,
    output logic                                 rsp_valid,
    output logic      [ptwe_pkg::PHYS_W-1:0]     phys_address,
    output logic      [ptwe_pkg::STAT_W-1:0]     status,
    output logic      [ptwe_pkg::CNT_W-1:0]      access_count,
    output logic      [ptwe_pkg::CNT_W-1:0]      hit_count,
    output logic      [ptwe_pkg::CNT_W-1:0]      from_free_count,
    output logic      [ptwe_pkg::CNT_W-1:0]      fault_count,
    output logic      [ptwe_pkg::PAGES_W-1:0]    used_pages,
    output logic      [ptwe_pkg::PAGES_W-1:0]    free_pages
);
    import ptwe_pkg::*;

    logic [PROC_W-1:0]  proc_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [CFG_W-1:0]   total_reg;
    logic [CFG_W-1:0]   resv_reg;
    logic [PAGES_W-1:0] free_reg;
    logic [PAGES_W-1:0] used_reg [NUM_PROCS];
    logic [CNT_W-1:0]   acc_reg;
    logic [CNT_W-1:0]   hit_reg;
    logic [CNT_W-1:0]   alloc_reg;
    logic [CNT_W-1:0]   fault_reg;
    logic [NUM_ROWS-1:0] rowv_reg;
    logic [WORD_W-1:0]  tword_reg;
    logic [ROW_W-1:0]   evrow_reg;
    logic [PHYS_W-1:0]  res_phys_reg;
    logic [STAT_W-1:0]  res_stat_reg;

    logic               out_valid_reg;
    logic [PHYS_W-1:0]  out_phys_reg;
    logic [STAT_W-1:0]  out_stat_reg;
    logic [CNT_W-1:0]   out_acc_reg;
    logic [CNT_W-1:0]   out_hit_reg;
    logic [CNT_W-1:0]   out_alloc_reg;
    logic [CNT_W-1:0]   out_fault_reg;
    logic [PAGES_W-1:0] out_used_reg;
    logic [PAGES_W-1:0] out_free_reg;

    logic [VPN_W-1:0]   vpn;
    logic [OFF_W-1:0]   off;
    logic               oor;
    logic [VROW_W-1:0]  trow;
    logic [SLOT_W-1:0]  tslot;
    logic [WORD_W-1:0]  tbit;
    logic [WORD_W-1:0]  tword_live;
    logic               hit;
    logic               do_alloc;
    logic               do_fault;
    logic               ev_any;
    logic [ROW_W-1:0]   ev_row;
    logic [BIT_W-1:0]   ev_bit;
    logic [WORD_W-1:0]  ev_word;
    logic               same_row;
    logic [PAGES_W-1:0] newframe;
    logic [PAGES_W-1:0] pool_init;
    logic [CFG_W-1:0]   total_new;
    logic [CFG_W-1:0]   resv_new;
    logic [PAGES_W-1:0] tot_cap;

    logic               vram_we;
    logic [VROW_W-1:0]  vram_waddr;
    logic [WORD_W-1:0]  vram_wdata;
    logic [VROW_W-1:0]  vram_raddr;
    logic [WORD_W-1:0]  vram_rdata;
    logic               fram_we;
    logic [FRAME_W-1:0] fram_wdata;
    logic [SLOT_W-1:0]  fram_raddr;
    logic [FRAME_W-1:0] fram_rdata;

    assign vpn   = addr_reg[OFF_W +: VPN_W];
    assign off   = addr_reg[OFF_W-1:0];
    assign oor   = |addr_reg[ADDR_W-1:OFF_W+VPN_W];
    assign trow  = {proc_reg, vpn[VPN_W-1:BIT_W]};
    assign tslot = {proc_reg, vpn};
    assign tbit  = {{(WORD_W-1){1'b0}}, 1'b1} << vpn[BIT_W-1:0];

    // a row whose summary bit is clear reads as all zero
    assign tword_live = rowv_reg[trow] ? vram_rdata : '0;
    assign hit        = tword_live[vpn[BIT_W-1:0]];
    assign do_alloc   = !oor && !hit && (free_reg != '0);
    assign do_fault   = !oor && !hit && (free_reg == '0);
    assign newframe   = resv_reg + free_reg - 11'd1;
    assign same_row   = (evrow_reg == vpn[VPN_W-1:BIT_W]);

    // lowest nonempty row of this process
    always_comb
    begin
        ev_any = 1'b0;
        ev_row = '0;
        for (int i = ROWS_PER_PROC - 1; i >= 0; i--)
        begin
            if (rowv_reg[{proc_reg, ROW_W'(i)}])
            begin
                ev_any = 1'b1;
                ev_row = ROW_W'(i);
            end
        end
    end

    // lowest valid page within the fetched row
    always_comb
    begin
        ev_bit = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (vram_rdata[i])
            begin
                ev_bit = BIT_W'(i);
            end
        end
    end

    always_comb
    begin
        ev_word = vram_rdata & ~({{(WORD_W-1){1'b0}}, 1'b1} << ev_bit);
        if (same_row)
        begin
            ev_word = ev_word | tbit;
        end
    end

    assign stat.evict    = do_fault && ev_any;
    assign stat.out_free = !out_valid_reg || rsp_ready;

    // pool size from the registers as they stand after this write
    always_comb
    begin
        total_new = total_reg;
        resv_new  = resv_reg;
        case (cfg_index)
            CFG_TOTAL:    total_new = cfg_data;
            CFG_RESERVED: resv_new  = cfg_data;
            default:      total_new = total_reg;
        endcase
        tot_cap   = (total_new > PHYS_PAGES) ? PHYS_PAGES : total_new;
        pool_init = (tot_cap > resv_new) ? (tot_cap - resv_new) : '0;
    end

    always_comb
    begin
        vram_raddr = cmd.lookup ? trow : {proc_reg, ev_row};
        fram_raddr = cmd.lookup ? tslot : {proc_reg, evrow_reg, ev_bit};
        vram_we    = 1'b0;
        vram_waddr = trow;
        vram_wdata = tword_reg | tbit;
        fram_we    = 1'b0;
        fram_wdata = fram_rdata;
        if (cmd.resolve && do_alloc)
        begin
            vram_we    = 1'b1;
            vram_wdata = tword_live | tbit;
            fram_we    = 1'b1;
            fram_wdata = newframe[FRAME_W-1:0];
        end
        else if (cmd.ev_clear)
        begin
            vram_we    = 1'b1;
            vram_waddr = {proc_reg, evrow_reg};
            vram_wdata = ev_word;
        end
        else if (cmd.ev_finish)
        begin
            vram_we = !same_row;
            fram_we = 1'b1;
        end
    end

    ptwe_ram #(.WIDTH(WORD_W), .DEPTH(NUM_ROWS)) u_vram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (vram_waddr),
        .wdata (vram_wdata),
        .raddr (vram_raddr),
        .rdata (vram_rdata)
    );

    ptwe_ram #(.WIDTH(FRAME_W), .DEPTH(NUM_SLOTS)) u_fram (
        .clk   (clk),
        .we    (fram_we),
        .waddr (tslot),
        .wdata (fram_wdata),
        .raddr (fram_raddr),
        .rdata (fram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            proc_reg <= proc_id;
            addr_reg <= address;
        end
        if (cmd.resolve)
        begin
            tword_reg <= tword_live;
            evrow_reg <= ev_row;
            if (oor)
            begin
                res_stat_reg <= ST_RANGE;
                res_phys_reg <= '0;
            end
            else if (hit)
            begin
                res_stat_reg <= ST_HIT;
                res_phys_reg <= {fram_rdata, off};
            end
            else if (do_alloc)
            begin
                res_stat_reg <= ST_FREE;
                res_phys_reg <= {newframe[FRAME_W-1:0], off};
            end
            else
            begin
                res_stat_reg <= ev_any ? ST_EVICT : ST_NOFRAME;
                res_phys_reg <= '0;
            end
        end
        if (cmd.ev_finish)
        begin
            res_phys_reg <= {fram_rdata, off};
        end
        if (cmd.push)
        begin
            out_phys_reg  <= res_phys_reg;
            out_stat_reg  <= res_stat_reg;
            out_acc_reg   <= acc_reg;
            out_hit_reg   <= hit_reg;
            out_alloc_reg <= alloc_reg;
            out_fault_reg <= fault_reg;
            out_used_reg  <= used_reg[proc_reg];
            out_free_reg  <= free_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= TOTAL_RST;
            resv_reg      <= RESERVED_RST;
            free_reg      <= TOTAL_RST - RESERVED_RST;
            acc_reg       <= '0;
            hit_reg       <= '0;
            alloc_reg     <= '0;
            fault_reg     <= '0;
            rowv_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int p = 0; p < NUM_PROCS; p++)
            begin
                used_reg[p] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                total_reg <= total_new;
                resv_reg  <= resv_new;
                free_reg  <= pool_init;
            end
            if (cmd.capture)
            begin
                acc_reg <= acc_reg + 32'd1;
            end
            if (cmd.resolve)
            begin
                if (!oor && hit)
                begin
                    hit_reg <= hit_reg + 32'd1;
                end
                if (do_alloc)
                begin
                    alloc_reg          <= alloc_reg + 32'd1;
                    free_reg           <= free_reg - 11'd1;
                    used_reg[proc_reg] <= used_reg[proc_reg] + 11'd1;
                    rowv_reg[trow]     <= 1'b1;
                end
                if (do_fault)
                begin
                    fault_reg <= fault_reg + 32'd1;
                end
            end
            if (cmd.ev_clear)
            begin
                rowv_reg[{proc_reg, evrow_reg}] <= |ev_word;
            end
            if (cmd.ev_finish)
            begin
                rowv_reg[trow] <= 1'b1;
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign phys_address    = out_phys_reg;
    assign status          = out_stat_reg;
    assign access_count    = out_acc_reg;
    assign hit_count       = out_hit_reg;
    assign from_free_count = out_alloc_reg;
    assign fault_count     = out_fault_reg;
    assign used_pages      = out_used_reg;
    assign free_pages      = out_free_reg;

endmodule

`default_nettype wire

>>> hw/rtl/page_table_translate_with_evict_core.sv
// ---------------------------------------------------------------------------
// page_table_translate_with_evict_core
// Per-process page table translation with free-pool allocation and eviction.
// ---------------------------------------------------------------------------
// Usage:
//   req carries proc_id and a virtual byte address; rsp returns one item per
//   request: physical address, status and the running counters.
//   cfg_we/cfg_index/cfg_data write total_pages (index 0) or reserved_pages
//   (index 1); either write reloads the free pool. Write only while idle.
// Timing:
//   One item at a time. A hit, free-pool mapping, failure or out-of-range
//   item passes the table read, resolve and push steps; an eviction adds a
//   clear and a finish step, set by the two dependent reads of the valid-row
//   RAM and the frame RAM. req.ready returns in the cycle the result shows,
//   so a new item is taken only once the previous result has been pushed.
// Reset:
//   Clears counters, per-process counts and the row summary bits that mark
//   the page tables empty; no clearing pass is needed.
// Stall:
//   The result waits in the output register; a finished item holds in the
//   sequencer until that register frees, and no new item is taken meanwhile.
// ---------------------------------------------------------------------------
`default_nettype none

module page_table_translate_with_evict_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    ptwe_req_if.sink                           req,
    ptwe_rsp_if.source                         rsp,
    input  wire logic                          cfg_we,
    input  wire logic [ptwe_pkg::CIDX_W-1:0]   cfg_index,
    input  wire logic [ptwe_pkg::CFG_W-1:0]    cfg_data
);
    import ptwe_pkg::*;

    ptwe_cmd_t  cmd;
    ptwe_stat_t stat;
    logic       ready;

    ptwe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    assign req.ready = ready;

    ptwe_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .proc_id         (req.proc_id),
        .address         (req.address),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .rsp_ready       (rsp.ready),
        .rsp_valid       (rsp.valid),
        .phys_address    (rsp.phys_address),
        .status          (rsp.status),
        .access_count    (rsp.access_count),
        .hit_count       (rsp.hit_count),
        .from_free_count (rsp.from_free_count),
        .fault_count     (rsp.fault_count),
        .used_pages      (rsp.used_pages),
        .free_pages      (rsp.free_pages)
    );

endmodule

`default_nettype wire

>>> hw/rtl/ptwe_checker.sv
// ---------------------------------------------------------------------------
// ptwe_checker
// Port-level checks on the translator, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module ptwe_port_props (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    input  wire logic                          req_ready,
    input  wire logic                          rsp_valid,
    input  wire logic                          rsp_ready,
    input  wire logic [ptwe_pkg::PHYS_W-1:0]   phys_address,
    input  wire logic [ptwe_pkg::STAT_W-1:0]   status
);
    import ptwe_pkg::*;

    // one item in flight: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while previous item in flight");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status == ST_HIT || status == ST_FREE || status == ST_EVICT ||
                       status == ST_NOFRAME || status == ST_RANGE))
        else $error("unknown status code");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_NOFRAME || status == ST_RANGE) |-> phys_address == '0)
        else $error("failed translation with nonzero address");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(phys_address) && $stable(status))
        else $error("stalled result dropped or changed");

endmodule

bind page_table_translate_with_evict_core ptwe_port_props u_ptwe_port_props (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .phys_address (rsp.phys_address),
    .status       (rsp.status)
);

`default_nettype wire
